// ===== design/gn3_pkg.sv =====
// Shared types, constants and helper functions of the 3D gradient noise point evaluator.
package gn3_pkg;

  localparam int TableSize   = 256;
  localparam int MaxGranLog2 = 8;
  localparam int IdxW        = $clog2(TableSize);
  localparam int GranW       = 4;
  localparam int OffW        = 8;
  localparam int GradW       = 16;
  localparam int WeightW     = 17;
  localparam int DotW        = 36;
  localparam int AccW        = 40;
  localparam int StageCnt    = 8;
  localparam logic [GranW-1:0] GranReset = 4'd2;

  localparam logic [1:0] AddrGran = 2'd0;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_POINT = 1'b1
  } req_type_e;

  typedef struct packed {
    logic signed [GradW-1:0] gx;
    logic signed [GradW-1:0] gy;
    logic signed [GradW-1:0] gz;
  } grad_t;

  typedef struct packed {
    logic            is_write;
    logic [3:0]      lg;
    logic [IdxW-1:0] cx;
    logic [IdxW-1:0] cy;
    logic [IdxW-1:0] cz;
    logic [OffW-1:0] oi;
    logic [OffW-1:0] oj;
    logic [OffW-1:0] ok;
  } point_t;

  function automatic logic [3:0] clamp_lg(input logic [GranW-1:0] g);
    logic [3:0] r;
    r = g;
    if (r < 4'd1) r = 4'd1;
    if (r > 4'(MaxGranLog2)) r = 4'(MaxGranLog2);
    return r;
  endfunction

endpackage

// ===== design/gradient_noise_3d_point.sv =====
// Throughput: one beat per cycle; the pipeline advances whenever its output slot is free.
// Hash: three chained permutation lookups, gradient read, dot, three blend levels, scale.
// Reset: rst_ni clears valid bits and sets granularity_log2 to 2.
// Table contents are undefined until written; nothing clears them.
module gradient_noise_3d_point import gn3_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [1:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     req_type_i,
  input  logic [7:0]               entry_index_i,
  input  logic [7:0]               perm_value_i,
  input  logic signed [15:0]       grad_x_i,
  input  logic signed [15:0]       grad_y_i,
  input  logic signed [15:0]       grad_z_i,
  input  logic [7:0]               corner_x_i,
  input  logic [7:0]               corner_y_i,
  input  logic [7:0]               corner_z_i,
  input  logic [7:0]               off_i_i,
  input  logic [7:0]               off_j_i,
  input  logic [7:0]               off_k_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [15:0]       noise_value_o,
  output logic                     write_ack_o
);

  logic [GranW-1:0] gran_q;
  logic             en;
  logic             accept;
  logic             wr;
  logic [StageCnt-1:0] vld_q;
  point_t           pt_in;
  point_t           pt_q [StageCnt];
  logic [IdxW-1:0]  h [8];
  grad_t            grad_mem [8][TableSize];
  logic [2:0]       gwr_q;
  logic [IdxW-1:0]  gidx_q [3];
  grad_t            gval_q [3];
  grad_t            g_q [8];
  logic signed [DotW-1:0] dot_q [8];
  logic signed [AccW-1:0] l1 [4];
  logic signed [AccW-1:0] l2 [2];
  logic signed [AccW-1:0] l3;
  logic [WeightW-1:0] wi, wj, wk;
  logic [WeightW-1:0] wi_q [3], wj_q [2], wk_q;
  logic signed [AccW-1:0] rnd;
  logic signed [AccW-1:0] scaled;
  logic signed [15:0]     sat;
  logic signed [9:0]      di [2], dj [2], dk [2];
  logic [OffW-1:0]        msk;

  assign pready = 1'b1;
  assign prdata = (paddr == AddrGran) ? 32'(gran_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gran_q <= GranReset;
    end else if (psel && penable && pwrite && paddr == AddrGran) begin
      gran_q <= pwdata[GranW-1:0];
    end
  end

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;
  assign accept     = in_valid_i && en;
  assign wr         = accept && (req_type_i == REQ_WRITE);

  always_comb begin
    pt_in.is_write = (req_type_i == REQ_WRITE);
    pt_in.lg       = clamp_lg(gran_q);
    msk            = OffW'((9'd1 << pt_in.lg) - 9'd1);
    pt_in.cx       = corner_x_i;
    pt_in.cy       = corner_y_i;
    pt_in.cz       = corner_z_i;
    pt_in.oi       = off_i_i & msk;
    pt_in.oj       = off_j_i & msk;
    pt_in.ok       = off_k_i & msk;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[StageCnt-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pt_q[0] <= pt_in;
      for (int s = 1; s < StageCnt; s++) begin
        pt_q[s] <= pt_q[s-1];
      end
    end
  end

  gn3_hash u_hash (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .wr_i     (wr),
    .wr_idx_i (entry_index_i),
    .wr_val_i (perm_value_i),
    .cx_i     (corner_x_i),
    .cy_i     (corner_y_i),
    .cz_i     (corner_z_i),
    .h_o      (h)
  );

  // carry a table write to the stage where the gradient copies are read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gwr_q <= '0;
    end else if (en) begin
      gwr_q <= {gwr_q[1:0], wr};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      gidx_q[0] <= entry_index_i;
      gval_q[0] <= '{gx: grad_x_i, gy: grad_y_i, gz: grad_z_i};
      gidx_q[1] <= gidx_q[0];
      gval_q[1] <= gval_q[0];
      gidx_q[2] <= gidx_q[1];
      gval_q[2] <= gval_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && gwr_q[2]) begin
      for (int c = 0; c < 8; c++) begin
        grad_mem[c][gidx_q[2]] <= gval_q[2];
      end
    end
  end

  // stage 4: gradient fetch
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 8; c++) begin
        g_q[c] <= grad_mem[c][h[c]];
      end
    end
  end

  always_comb begin
    di[0] = $signed({2'b0, pt_q[3].oi});
    dj[0] = $signed({2'b0, pt_q[3].oj});
    dk[0] = $signed({2'b0, pt_q[3].ok});
    di[1] = di[0] - $signed(10'(10'd1 << pt_q[3].lg));
    dj[1] = dj[0] - $signed(10'(10'd1 << pt_q[3].lg));
    dk[1] = dk[0] - $signed(10'(10'd1 << pt_q[3].lg));
  end

  // stage 5: corner dots, x component pairs with k
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 8; c++) begin
        dot_q[c] <= DotW'(26'(g_q[c].gx) * 26'(dk[c%2]))
                  + DotW'(26'(g_q[c].gy) * 26'(dj[(c/2)%2]))
                  + DotW'(26'(g_q[c].gz) * 26'(di[c/4]));
      end
    end
  end

  gn3_weight u_wi (.clk_i(clk_i), .en_i(en), .o_i(pt_q[1].oi), .lg_i(pt_q[1].lg), .w_o(wi));
  gn3_weight u_wj (.clk_i(clk_i), .en_i(en), .o_i(pt_q[1].oj), .lg_i(pt_q[1].lg), .w_o(wj));
  gn3_weight u_wk (.clk_i(clk_i), .en_i(en), .o_i(pt_q[1].ok), .lg_i(pt_q[1].lg), .w_o(wk));

  always_ff @(posedge clk_i) begin
    if (en) begin
      wk_q    <= wk;
      wj_q[0] <= wj;
      wj_q[1] <= wj_q[0];
      wi_q[0] <= wi;
      wi_q[1] <= wi_q[0];
      wi_q[2] <= wi_q[1];
    end
  end

  for (genvar p = 0; p < 4; p++) begin : g_l1
    gn3_lerp u_l1 (
      .clk_i (clk_i), .en_i (en), .w_i (wk_q),
      .a_i   (AccW'(dot_q[2*p])), .b_i (AccW'(dot_q[2*p+1])), .y_o (l1[p])
    );
  end

  for (genvar p = 0; p < 2; p++) begin : g_l2
    gn3_lerp u_l2 (
      .clk_i (clk_i), .en_i (en), .w_i (wj_q[1]),
      .a_i   (l1[2*p]), .b_i (l1[2*p+1]), .y_o (l2[p])
    );
  end

  gn3_lerp u_l3 (
    .clk_i (clk_i), .en_i (en), .w_i (wi_q[2]),
    .a_i   (l2[0]), .b_i (l2[1]), .y_o (l3)
  );

  always_comb begin
    rnd    = l3 + (AccW'(1) <<< (pt_q[StageCnt-1].lg - 4'd1));
    scaled = rnd >>> pt_q[StageCnt-1].lg;
    if (scaled > AccW'(32767)) begin
      sat = 16'sd32767;
    end else if (scaled < -AccW'(32768)) begin
      sat = -16'sd32768;
    end else begin
      sat = 16'(scaled);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= vld_q[StageCnt-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      noise_value_o <= pt_q[StageCnt-1].is_write ? 16'sd0 : sat;
      write_ack_o   <= pt_q[StageCnt-1].is_write;
    end
  end

`ifndef SYNTH
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(noise_value_o))
    else $error("result beat changed under stall");
  a_ack_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_ack_o |-> noise_value_o == 16'sd0)
    else $error("write ack with nonzero noise");
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");
`endif

endmodule

// ===== design/gn3_weight.sv =====
// Spline weight 3t^2-2t^3 in Q0.16 from a masked step offset, two register stages.
module gn3_weight import gn3_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [OffW-1:0]    o_i,
  input  logic [3:0]         lg_i,
  output logic [WeightW-1:0] w_o
);

  logic [15:0] sq_q;
  logic [9:0]  fac_q;
  logic [3:0]  lg_q;
  logic [25:0] num;
  logic [42:0] shifted;
  logic [4:0]  sh;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q  <= 16'(o_i) * 16'(o_i);
      fac_q <= 10'((10'd3 << lg_i) - (10'(o_i) << 1));
      lg_q  <= lg_i;
    end
  end

  always_comb begin
    num     = 26'(sq_q) * 26'(fac_q);
    sh      = 5'(lg_q) * 5'd3;
    shifted = ((43'(num) << 16) + (43'd1 << (sh - 5'd1))) >> sh;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_o <= WeightW'(shifted);
    end
  end

endmodule

// ===== design/gn3_lerp.sv =====
// Registered blend a + w*(b-a) with round-half-up rounding at Q0.16 weight.
module gn3_lerp import gn3_pkg::*; (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [WeightW-1:0]     w_i,
  input  logic signed [AccW-1:0] a_i,
  input  logic signed [AccW-1:0] b_i,
  output logic signed [AccW-1:0] y_o
);

  logic signed [AccW+WeightW+2:0] sum;

  always_comb begin
    sum = ((AccW+WeightW+3)'(a_i) <<< 16)
        + $signed({1'b0, w_i}) * (AccW+WeightW+3)'(b_i - a_i)
        + (AccW+WeightW+3)'(32768);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_o <= AccW'(sum >>> 16);
    end
  end

endmodule

// ===== design/gn3_hash.sv =====
// Permutation hash of the eight cell corners over replicated table copies, three stages.
module gn3_hash import gn3_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            wr_i,
  input  logic [IdxW-1:0] wr_idx_i,
  input  logic [IdxW-1:0] wr_val_i,
  input  logic [IdxW-1:0] cx_i,
  input  logic [IdxW-1:0] cy_i,
  input  logic [IdxW-1:0] cz_i,
  output logic [IdxW-1:0] h_o [8]
);

  logic [IdxW-1:0] perm_a [TableSize];
  logic [IdxW-1:0] perm_b [2][TableSize];
  logic [IdxW-1:0] perm_c [8][TableSize];
  logic [IdxW-1:0] hx_q [2];
  logic [IdxW-1:0] y1_q, z1_q;
  logic [IdxW-1:0] hy_q [4];
  logic [IdxW-1:0] z0_q;
  logic [1:0]      pwr_q;
  logic [IdxW-1:0] pidx_q [2];
  logic [IdxW-1:0] pval_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwr_q <= '0;
    end else if (en_i) begin
      pwr_q <= {pwr_q[0], wr_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pidx_q[0] <= wr_idx_i;
      pval_q[0] <= wr_val_i;
      pidx_q[1] <= pidx_q[0];
      pval_q[1] <= pval_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      perm_a[wr_idx_i] <= wr_val_i;
    end
  end

  for (genvar g = 0; g < 2; g++) begin : g_b
    always_ff @(posedge clk_i) begin
      if (en_i && pwr_q[0]) begin
        perm_b[g][pidx_q[0]] <= pval_q[0];
      end
    end
  end

  for (genvar g = 0; g < 8; g++) begin : g_c
    always_ff @(posedge clk_i) begin
      if (en_i && pwr_q[1]) begin
        perm_c[g][pidx_q[1]] <= pval_q[1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hx_q[0] <= perm_a[cx_i];
      hx_q[1] <= perm_a[cx_i + IdxW'(1)];
      y1_q    <= cy_i;
      z1_q    <= cz_i;
    end
  end

  for (genvar x = 0; x < 2; x++) begin : g_y
    for (genvar y = 0; y < 2; y++) begin : g_yy
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          hy_q[x*2+y] <= perm_b[x][hx_q[x] + y1_q + IdxW'(y)];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z0_q <= z1_q;
    end
  end

  for (genvar c = 0; c < 8; c++) begin : g_z
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        h_o[c] <= perm_c[c][hy_q[c/2] + z0_q + IdxW'(c%2)];
      end
    end
  end

endmodule

// ===== tb/gradient_noise_3d_point_tb.sv =====
// Self-checking testbench for the 3D gradient noise point evaluator.
`timescale 1ns / 1ps

module gradient_noise_3d_point_tb;
  import gn3_pkg::*;

  localparam logic [1:0] AddrSpare = 2'd1;
  localparam int CycleLimit = 300000;
  localparam int DrainCycles = 20;

  typedef struct {
    req_type_e       kind;
    logic [7:0]      entry;
    logic [7:0]      perm;
    logic [15:0]     gx, gy, gz;
    logic [7:0]      cx, cy, cz;
    logic [7:0]      oi, oj, ok;
  } beat_t;

  typedef struct {
    logic signed [15:0] noise;
    logic               ack;
  } noise_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic req_type_i = 1'b0;
  logic [7:0] entry_index_i = '0, perm_value_i = '0;
  logic signed [15:0] grad_x_i = '0, grad_y_i = '0, grad_z_i = '0;
  logic [7:0] corner_x_i = '0, corner_y_i = '0, corner_z_i = '0;
  logic [7:0] off_i_i = '0, off_j_i = '0, off_k_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [15:0] noise_value_o;
  logic write_ack_o;

  gradient_noise_3d_point i_dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  logic [7:0]  perm_mem [TableSize];
  grad_t       grad_mem [TableSize];
  logic [3:0]  gran_reg = GranReset;
  noise_result_t expected_q[$];
  int  mismatches = 0;
  int  beats_sent = 0;
  int  results_seen = 0;
  int  points_sent = 0;
  int  cycles = 0;
  bit  gaps_on = 1'b1;
  bit  stalls_on = 1'b1;
  int  hold_req = 0;

  function automatic logic [7:0] hash_corner(logic [7:0] x, logic [7:0] y, logic [7:0] z);
    logic [7:0] h;
    h = perm_mem[x];
    h = perm_mem[8'(h + y)];
    return perm_mem[8'(h + z)];
  endfunction

  function automatic longint spline_w(longint o, int lg);
    longint n, num;
    n = longint'(1) << lg;
    num = o * o * (3 * n - 2 * o);
    return ((num << 16) + (longint'(1) << (3 * lg - 1))) >>> (3 * lg);
  endfunction

  function automatic longint blend(longint w, longint a, longint b);
    return (a * 65536 + w * (b - a) + 32768) >>> 16;
  endfunction

  function automatic logic signed [15:0] predict_noise(beat_t b);
    int lg;
    longint n, r;
    longint di[2], dj[2], dk[2], dots[8];
    longint wi, wj, wk, e, f;
    logic [7:0] h;
    lg = gran_reg;
    if (lg < 1) lg = 1;
    if (lg > MaxGranLog2) lg = MaxGranLog2;
    n = longint'(1) << lg;
    di[0] = b.oi & (n - 1); dj[0] = b.oj & (n - 1); dk[0] = b.ok & (n - 1);
    di[1] = di[0] - n; dj[1] = dj[0] - n; dk[1] = dk[0] - n;
    for (int c = 0; c < 8; c++) begin
      h = hash_corner(8'(b.cx + c[2]), 8'(b.cy + c[1]), 8'(b.cz + c[0]));
      dots[c] = longint'(grad_mem[h].gx) * dk[c[0]] + longint'(grad_mem[h].gy) * dj[c[1]]
              + longint'(grad_mem[h].gz) * di[c[2]];
    end
    wi = spline_w(di[0], lg);
    wj = spline_w(dj[0], lg);
    wk = spline_w(dk[0], lg);
    e = blend(wj, blend(wk, dots[0], dots[1]), blend(wk, dots[2], dots[3]));
    f = blend(wj, blend(wk, dots[4], dots[5]), blend(wk, dots[6], dots[7]));
    r = (blend(wi, e, f) + n / 2) >>> lg;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_beat(beat_t b);
    int gap;
    noise_result_t res;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    req_type_i = b.kind;
    entry_index_i = b.entry; perm_value_i = b.perm;
    grad_x_i = b.gx; grad_y_i = b.gy; grad_z_i = b.gz;
    corner_x_i = b.cx; corner_y_i = b.cy; corner_z_i = b.cz;
    off_i_i = b.oi; off_j_i = b.oj; off_k_i = b.ok;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (b.kind == REQ_WRITE) begin
      perm_mem[b.entry] = b.perm;
      grad_mem[b.entry] = '{gx: b.gx, gy: b.gy, gz: b.gz};
      res = '{noise: '0, ack: 1'b1};
    end else begin
      res = '{noise: predict_noise(b), ack: 1'b0};
      points_sent++;
    end
    expected_q.push_back(res);
    beats_sent++;
  endtask

  task automatic go_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  function automatic beat_t rand_beat(bit is_write);
    beat_t b;
    b.kind = is_write ? REQ_WRITE : REQ_POINT;
    b.entry = 8'($urandom); b.perm = 8'($urandom);
    if (is_write) begin
      b.gx = 16'($urandom_range(0, 32768) - 16384);
      b.gy = 16'($urandom_range(0, 32768) - 16384);
      b.gz = 16'($urandom_range(0, 32768) - 16384);
    end else begin
      b.gx = 16'($urandom); b.gy = 16'($urandom); b.gz = 16'($urandom);
    end
    b.cx = 8'($urandom); b.cy = 8'($urandom); b.cz = 8'($urandom);
    b.oi = 8'($urandom); b.oj = 8'($urandom); b.ok = 8'($urandom);
    return b;
  endfunction

  task automatic wait_drained();
    go_idle();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (StageCnt + 3) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [1:0] addr, logic [31:0] data);
    wait_drained();
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; paddr = addr; pwdata = data; penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == AddrGran) gran_reg = data[3:0];
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic reg_check();
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b0; paddr = AddrGran; penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[3:0] !== gran_reg) begin
      mismatches++;
      if (mismatches <= 10)
        $display("granularity readback: expected %0d got %0d", gran_reg, prdata[3:0]);
    end
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0;
  endtask

  task automatic test_fill_tables();
    beat_t b;
    for (int i = 0; i < TableSize; i++) begin
      b = rand_beat(1'b1);
      b.entry = 8'(i);
      if (i < 2) begin
        b.gx = i ? -16'sd16384 : 16'sd16384;
        b.gy = b.gx; b.gz = b.gx;
        b.perm = i ? 8'hFF : 8'h00;
      end
      send_beat(b);
    end
  endtask

  task automatic test_directed();
    beat_t b;
    for (int i = 0; i < 12; i++) begin
      b = rand_beat(1'b0);
      b.cx = i[0] ? 8'hFF : 8'h00;
      b.cy = i[1] ? 8'hFF : 8'h00;
      b.cz = i[2] ? 8'hFF : 8'h00;
      b.oi = (i % 3 == 0) ? 8'h00 : (i % 3 == 1) ? 8'h03 : 8'hFF;
      b.oj = (i % 4 == 0) ? 8'hFF : 8'h02;
      b.ok = (i % 2 == 0) ? 8'h01 : 8'hFC;
      send_beat(b);
    end
    reg_write(AddrSpare, 32'hF);
    reg_check();
    for (int i = 0; i < 4; i++) send_beat(rand_beat(1'b0));
  endtask

  task automatic test_granularity();
    int settings[] = '{1, 8, 0, 15, 9, 3, 5, 7};
    for (int s = 0; s < settings.size(); s++) begin
      reg_write(AddrGran, 32'(settings[s]) | ($urandom & 32'hFFFF_FFF0));
      reg_check();
      for (int i = 0; i < 45; i++) send_beat(rand_beat($urandom_range(0, 4) == 0));
    end
  endtask

  task automatic test_back_pressure();
    gaps_on = 1'b0;
    hold_req = 200;
    for (int i = 0; i < 40; i++) send_beat(rand_beat($urandom_range(0, 3) == 0));
    gaps_on = 1'b1;
  endtask

  task automatic test_pause_and_resume();
    wait_drained();
    stalls_on = 1'b0;
    gaps_on = 1'b0;
    for (int i = 0; i < 40; i++) send_beat(rand_beat($urandom_range(0, 4) == 0));
    stalls_on = 1'b1;
    gaps_on = 1'b1;
  endtask

  task automatic test_random();
    reg_write(AddrGran, 32'($urandom_range(1, 8)));
    for (int i = 0; i < 60; i++) send_beat(rand_beat($urandom_range(0, 4) == 0));
  endtask

  int hold_left = 0;
  always @(negedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i = 1'b1;
    end else if (!stalls_on) begin
      out_stall_i = 1'b0;
    end else if ($urandom_range(0, 199) == 0) begin
      hold_left = $urandom_range(15, 50);
      out_stall_i = 1'b1;
    end else begin
      out_stall_i = ($urandom_range(0, 99) < 25);
    end
  end

  always @(posedge clk_i) begin
    noise_result_t want;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: noise %0d", noise_value_o);
      end else begin
        want = expected_q.pop_front();
        if (noise_value_o !== want.noise || write_ack_o !== want.ack) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected noise %0d ack %0b, got noise %0d ack %0b",
                     results_seen, want.noise, want.ack, noise_value_o, write_ack_o);
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_fill_tables();
    test_directed();
    test_granularity();
    test_back_pressure();
    test_pause_and_resume();
    test_random();
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_q.size() != 0) mismatches++;
    $display("Sent %0d beats (%0d noise points) over %0d cycles, %0d results checked,",
             beats_sent, points_sent, cycles, results_seen);
    $display("granularity swept incl. clamped settings, with long stalls and a full drain.");
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== gradient_noise_3d_point.f =====
design/gn3_pkg.sv
design/gn3_weight.sv
design/gn3_lerp.sv
design/gn3_hash.sv
design/gradient_noise_3d_point.sv
tb/gradient_noise_3d_point_tb.sv
